>>> hw/rtl/twbcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Three-wire BCD register access package
// Shared types and codes for the front end, the job queue and the serializer.
// ----------------------------------------------------------------------------
package twbcd_pkg;

    // Request codes on the input side.
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // Job kinds handed from the front end to the serializer.
    localparam logic [2:0] KIND_WRITE     = 3'd0;
    localparam logic [2:0] KIND_READ      = 3'd1;
    localparam logic [2:0] KIND_BIT_ACK   = 3'd2;
    localparam logic [2:0] KIND_READ_DONE = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;

    // Final slot index of the multi-slot jobs.
    localparam logic [4:0] WRITE_LAST_SLOT = 5'd16;
    localparam logic [4:0] READ_LAST_SLOT  = 5'd8;

    // Depth of the queue between front end and serializer.
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

    // Reciprocal multiply for division by ten of an 8-bit value.
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] address;
        logic [7:0] value;
        logic       sampled_bit;
    } item_t;

    typedef struct packed {
        logic       chip_enable;
        logic       drive_data;
        logic       data_bit;
        logic       clock_pulse;
        logic [7:0] read_value;
        logic       read_done;
        logic       error;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] word;
        logic [7:0]  read_value;
    } job_t;

endpackage
`default_nettype wire

>>> hw/rtl/twbcd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts request transactions, tracks the read phase and turns each item
// into one job for the serializer.
// ----------------------------------------------------------------------------
module twbcd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire twbcd_pkg::item_t item,
    input  wire logic             q_full,
    output logic                  q_push,
    output twbcd_pkg::job_t       q_job
);

    logic       awaiting_reg, awaiting_next;
    logic [7:0] rx_bits_reg, rx_bits_next;
    logic [2:0] bit_pos_reg, bit_pos_next;

    logic [15:0] div_prod;
    logic [4:0]  tens;
    logic [7:0]  tens_x10;
    logic [7:0]  ones;
    logic [7:0]  bcd_byte;
    logic [7:0]  rx_with_bit;
    logic [7:0]  rx_final;
    logic [7:0]  bcd_to_dec;

    assign q_push = push & ~q_full;

    // Value to BCD: divide by ten through a reciprocal multiply.
    always_comb
    begin
        div_prod = 16'(item.value) * 16'(twbcd_pkg::DIV10_MUL);
        tens     = div_prod[15:twbcd_pkg::DIV10_SHIFT];
        tens_x10 = 8'({tens, 3'b000}) + 8'({tens, 1'b0});
        ones     = item.value - tens_x10;
        bcd_byte = {tens[3:0], ones[3:0]};
    end

    // Received byte with the current sample, and its decimal value.
    always_comb
    begin
        rx_with_bit = rx_bits_reg | (8'(item.sampled_bit) << bit_pos_reg);
        rx_final    = rx_bits_reg | {item.sampled_bit, 7'b0000000};
        bcd_to_dec  = 8'({rx_final[7:4], 3'b000}) + 8'({rx_final[7:4], 1'b0})
                    + 8'(rx_final[3:0]);
    end

    // Classify the transaction against the current phase.
    always_comb
    begin
        q_job          = '0;
        q_job.kind     = twbcd_pkg::KIND_ERROR;
        awaiting_next  = awaiting_reg;
        rx_bits_next   = rx_bits_reg;
        bit_pos_next   = bit_pos_reg;
        unique case (item.cmd)
            twbcd_pkg::CMD_WRITE:
            begin
                if (!awaiting_reg)
                begin
                    q_job.kind = twbcd_pkg::KIND_WRITE;
                    q_job.word = {bcd_byte, item.address};
                end
            end
            twbcd_pkg::CMD_READ:
            begin
                if (!awaiting_reg)
                begin
                    q_job.kind    = twbcd_pkg::KIND_READ;
                    q_job.word    = {8'h00, item.address + 8'd1};
                    awaiting_next = 1'b1;
                    rx_bits_next  = '0;
                    bit_pos_next  = '0;
                end
            end
            twbcd_pkg::CMD_SAMPLE:
            begin
                if (awaiting_reg)
                begin
                    if (bit_pos_reg == 3'd7)
                    begin
                        q_job.kind       = twbcd_pkg::KIND_READ_DONE;
                        q_job.read_value = bcd_to_dec;
                        awaiting_next    = 1'b0;
                        rx_bits_next     = '0;
                        bit_pos_next     = '0;
                    end
                    else
                    begin
                        q_job.kind   = twbcd_pkg::KIND_BIT_ACK;
                        rx_bits_next = rx_with_bit;
                        bit_pos_next = bit_pos_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                q_job.kind = twbcd_pkg::KIND_ERROR;
            end
        endcase
    end

    // Phase state advances only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            rx_bits_reg  <= '0;
            bit_pos_reg  <= '0;
        end
        else if (q_push)
        begin
            awaiting_reg <= awaiting_next;
            rx_bits_reg  <= rx_bits_next;
            bit_pos_reg  <= bit_pos_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/twbcd_jobq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out buffer that decouples the front end from the
// serializer.
// ----------------------------------------------------------------------------
module twbcd_jobq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire twbcd_pkg::job_t wr_job,
    input  wire logic            rd_en,
    output twbcd_pkg::job_t      head,
    output logic                 full,
    output logic                 empty
);

    twbcd_pkg::job_t entry_reg [twbcd_pkg::JOBQ_DEPTH];

    logic [twbcd_pkg::JOBQ_PTR_W-1:0] wr_ptr_reg;
    logic [twbcd_pkg::JOBQ_PTR_W-1:0] rd_ptr_reg;
    logic [twbcd_pkg::JOBQ_CNT_W-1:0] count_reg, count_next;
    logic                             do_wr;
    logic                             do_rd;

    assign full  = (count_reg == twbcd_pkg::JOBQ_CNT_W'(twbcd_pkg::JOBQ_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];
    assign do_wr = wr_en & ~full;
    assign do_rd = rd_en & ~empty;

    // Occupancy bookkeeping.
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/twbcd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot serializer
// Expands the job at the head of the queue into bus bit slots, one per cycle while
// the registered result stage is free or being popped.
// ----------------------------------------------------------------------------
module twbcd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire twbcd_pkg::job_t head,
    input  wire logic            q_empty,
    output logic                 q_pop,
    input  wire logic            pop,
    output logic                 empty,
    output twbcd_pkg::result_t   result
);

    logic [4:0]         slot_reg;
    logic               out_valid_reg;
    twbcd_pkg::result_t out_reg;
    twbcd_pkg::result_t slot;
    logic               advance;
    logic               word_bit;

    assign advance  = ~q_empty & (~out_valid_reg | pop);
    assign q_pop    = advance & slot.last;
    assign word_bit = head.word[slot_reg[3:0]];
    assign empty    = ~out_valid_reg;
    assign result   = out_reg;

    // Build the slot for the current job and slot index.
    always_comb
    begin
        slot = '0;
        unique case (head.kind)
            twbcd_pkg::KIND_WRITE:
            begin
                slot.drive_data = 1'b1;
                if (slot_reg == twbcd_pkg::WRITE_LAST_SLOT)
                begin
                    slot.last = 1'b1;
                end
                else
                begin
                    slot.chip_enable = 1'b1;
                    slot.data_bit    = word_bit;
                    slot.clock_pulse = 1'b1;
                end
            end
            twbcd_pkg::KIND_READ:
            begin
                slot.chip_enable = 1'b1;
                if (slot_reg == twbcd_pkg::READ_LAST_SLOT)
                begin
                    slot.last = 1'b1;
                end
                else
                begin
                    slot.drive_data  = 1'b1;
                    slot.data_bit    = word_bit;
                    slot.clock_pulse = 1'b1;
                end
            end
            twbcd_pkg::KIND_BIT_ACK:
            begin
                slot.chip_enable = 1'b1;
                slot.clock_pulse = 1'b1;
                slot.last        = 1'b1;
            end
            twbcd_pkg::KIND_READ_DONE:
            begin
                slot.read_value = head.read_value;
                slot.read_done  = 1'b1;
                slot.last       = 1'b1;
            end
            default:
            begin
                slot.error = 1'b1;
                slot.last  = 1'b1;
            end
        endcase
    end

    // Slot counter and result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                slot_reg      <= slot.last ? 5'd0 : slot_reg + 5'd1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= slot;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/three_wire_bcd_register_access_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A transaction's first slot is registered in a job queue entry and then in the result register.
// Throughput: the serializer emits one slot per cycle while the result stage is free or popped; a
// write expands into 17 slots, a read request into 9, and a sampled bit or a rejected item into 1;
// a two-entry job queue lets new transactions in while earlier ones are still being serialized.
// Reset: rst_n clears the read phase, the queue and the result stage; no transaction is pending.
// ----------------------------------------------------------------------------
// Three-wire BCD register access core
// Master side of a chip-enable, clock and data register bus with BCD
// conversion of written and read values.
// ----------------------------------------------------------------------------
module three_wire_bcd_register_access_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire twbcd_pkg::item_t item,
    output logic                  empty,
    input  wire logic             pop,
    output twbcd_pkg::result_t    result
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    twbcd_pkg::job_t q_job;
    twbcd_pkg::job_t q_head;

    assign full = q_full;

    // Front end: classification and read-phase tracking.
    twbcd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_job)
    );

    // Queue between front end and serializer.
    twbcd_jobq u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_job (q_job),
        .rd_en  (q_pop),
        .head   (q_head),
        .full   (q_full),
        .empty  (q_empty)
    );

    // Serializer and result stage.
    twbcd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // The queue is never both full and empty.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_full && q_empty))
        else $error("job queue reports full and empty together");

    // Error and read-completion slots always close their transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.error || result.read_done)) |-> result.last)
        else $error("single-slot result without last");

    // A completed read drops chip enable and releases the data line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.read_done) |-> (!result.chip_enable && !result.drive_data))
        else $error("read completion slot with bus still active");

    // The queue only releases a job when the serializer emits its last slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (!empty && result.last))
        else $error("job retired without a last slot");

endmodule
`default_nettype wire
